// ===== rtl/grid_maze_reachability_search_unit_defines.svh =====
// Assertion macros used by the checker of the maze search unit.
`ifndef GRID_MAZE_REACHABILITY_SEARCH_UNIT_DEFINES_SVH
`define GRID_MAZE_REACHABILITY_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GMRS_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GMRS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/gmrs_pkg.sv =====
// Package with the sizes, codes and types of the grid maze search unit.
`timescale 1ns / 1ps

package gmrs_pkg;

    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 16;
    localparam int ROW_W      = 4;
    localparam int COL_W      = 4;
    localparam int IDX_W      = ROW_W + COL_W;
    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int DEPTH_W    = IDX_W + 1;
    localparam int CFG_W      = 5;

    localparam logic [1:0] CODE_WALL = 2'd0;
    localparam logic [1:0] CODE_OPEN = 2'd1;
    localparam logic [1:0] CODE_SEEN = 2'd2;

    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_UP    = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_LEFT  = 2'd3
    } t_dir;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_CHECK   = 7'b0000010,
        S_NBR     = 7'b0000100,
        S_NWAIT   = 7'b0001000,
        S_POP     = 7'b0010000,
        S_POPWAIT = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

endpackage

// ===== rtl/grid_maze_reachability_search_unit.sv =====
// Top level of the grid maze reachability search unit with its cell map and path stack.
//
//  channel   direction  handshake                     payload
//  in        request    i_in_valid / o_in_stall       i_func i_row i_col i_cell_open
//                                                     i_goal_row i_goal_col
//  out       result     o_out_valid / i_out_stall     o_found
//  cfg       write      i_cfg_we                      i_cfg_idx i_cfg_data
//
// A load request leaves the input free. A search stalls the input until its result
// enters the output register: a goal check per cell, a cell map read per neighbor
// inside the grid, a skip per neighbor outside it, a backtrack through the path stack
// when no neighbor is open, and a hand-off; a start outside the grid only hands off.
// Reset is synchronous; it sets a 10-row by 15-column grid and clears the control state
// and all cell map valid bits, so every cell reads as a wall; no clearing pass is needed.
// A result waits in the output register while the out side stalls, and a search that
// finishes meanwhile keeps the input stalled until that register is free.
`timescale 1ns / 1ps

module grid_maze_reachability_search_unit import gmrs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_func,
    input  logic [ROW_W-1:0] i_row,
    input  logic [COL_W-1:0] i_col,
    input  logic             i_cell_open,
    input  logic [ROW_W-1:0] i_goal_row,
    input  logic [COL_W-1:0] i_goal_col,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_found,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [1:0]       cell_mem [CELL_COUNT];
    logic [IDX_W-1:0] stack_mem [CELL_COUNT];
    logic [CELL_COUNT-1:0] r_cell_vld;

    logic [1:0]       r_cm_rd;
    logic             r_cm_vld_rd;
    logic [IDX_W-1:0] r_st_rd;

    t_state           r_state, n_state;
    t_dir             r_dir, n_dir;
    logic [CFG_W-1:0] r_grid_rows, r_grid_cols;
    logic [ROW_W-1:0] r_top_row, n_top_row;
    logic [COL_W-1:0] r_top_col, n_top_col;
    logic [ROW_W-1:0] r_goal_row, n_goal_row;
    logic [COL_W-1:0] r_goal_col, n_goal_col;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic             r_found, n_found;
    logic             r_out_valid, n_out_valid;
    logic             r_out_found, n_out_found;

    logic [CFG_W-1:0] rows_used, cols_used;
    logic [ROW_W:0]   nbr_row_x;
    logic [COL_W:0]   nbr_col_x;
    logic             nbr_under;
    logic             nbr_inside;
    logic [IDX_W-1:0] nbr_idx;
    logic             start_inside;
    logic             goal_inside;
    logic             cell_is_open;
    logic             in_accept;
    logic [DEPTH_W-1:0] depth_less2;

    logic             cm_we;
    logic [IDX_W-1:0] cm_waddr;
    logic [1:0]       cm_wdata;
    logic             st_we;
    logic [IDX_W-1:0] st_waddr;
    logic [IDX_W-1:0] st_wdata;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign in_accept   = i_in_valid && !o_in_stall;

    assign rows_used = (r_grid_rows < CFG_W'(MAX_ROWS)) ? r_grid_rows : CFG_W'(MAX_ROWS);
    assign cols_used = (r_grid_cols < CFG_W'(MAX_COLS)) ? r_grid_cols : CFG_W'(MAX_COLS);

    assign start_inside = (CFG_W'(i_row) < rows_used) && (CFG_W'(i_col) < cols_used);
    assign goal_inside  = (CFG_W'(r_goal_row) < rows_used)
                       && (CFG_W'(r_goal_col) < cols_used);

    always_comb begin
        nbr_row_x = {1'b0, r_top_row};
        nbr_col_x = {1'b0, r_top_col};
        nbr_under = 1'b0;
        case (r_dir)
            DIR_DOWN: begin
                nbr_row_x = {1'b0, r_top_row} + (ROW_W+1)'(1);
            end
            DIR_UP: begin
                nbr_under = (r_top_row == '0);
                nbr_row_x = {1'b0, r_top_row} - (ROW_W+1)'(1);
            end
            DIR_RIGHT: begin
                nbr_col_x = {1'b0, r_top_col} + (COL_W+1)'(1);
            end
            DIR_LEFT: begin
                nbr_under = (r_top_col == '0);
                nbr_col_x = {1'b0, r_top_col} - (COL_W+1)'(1);
            end
            default: begin
                nbr_under = 1'b1;
            end
        endcase
    end

    assign nbr_inside = !nbr_under
                     && (CFG_W'(nbr_row_x) < rows_used)
                     && (CFG_W'(nbr_col_x) < cols_used);
    assign nbr_idx = {nbr_row_x[ROW_W-1:0], nbr_col_x[COL_W-1:0]};

    assign cell_is_open = r_cm_vld_rd && (r_cm_rd == CODE_OPEN);
    assign depth_less2  = r_depth - DEPTH_W'(2);

    always_comb begin
        n_state     = r_state;
        n_dir       = r_dir;
        n_top_row   = r_top_row;
        n_top_col   = r_top_col;
        n_goal_row  = r_goal_row;
        n_goal_col  = r_goal_col;
        n_depth     = r_depth;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        cm_we       = 1'b0;
        cm_waddr    = nbr_idx;
        cm_wdata    = CODE_SEEN;
        st_we       = 1'b0;
        st_waddr    = r_depth[IDX_W-1:0];
        st_wdata    = nbr_idx;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_func == FUNC_LOAD) begin
                        cm_we    = start_inside;
                        cm_waddr = {i_row, i_col};
                        cm_wdata = i_cell_open ? CODE_OPEN : CODE_WALL;
                    end else begin
                        n_goal_row = i_goal_row;
                        n_goal_col = i_goal_col;
                        n_top_row  = i_row;
                        n_top_col  = i_col;
                        n_found    = 1'b0;
                        if (start_inside) begin
                            cm_we    = 1'b1;
                            cm_waddr = {i_row, i_col};
                            st_we    = 1'b1;
                            st_waddr = '0;
                            st_wdata = {i_row, i_col};
                            n_depth  = DEPTH_W'(1);
                            n_state  = S_CHECK;
                        end else begin
                            n_depth = '0;
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (goal_inside && r_top_row == r_goal_row && r_top_col == r_goal_col) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_dir   = DIR_DOWN;
                    n_state = S_NBR;
                end
            end
            S_NBR: begin
                if (nbr_inside) begin
                    n_state = S_NWAIT;
                end else if (r_dir == DIR_LEFT) begin
                    n_state = S_POP;
                end else begin
                    n_dir = t_dir'(r_dir + 2'd1);
                end
            end
            S_NWAIT: begin
                if (cell_is_open) begin
                    cm_we = 1'b1;
                    if (r_depth < DEPTH_W'(CELL_COUNT)) begin
                        st_we     = 1'b1;
                        n_depth   = r_depth + DEPTH_W'(1);
                        n_top_row = nbr_row_x[ROW_W-1:0];
                        n_top_col = nbr_col_x[COL_W-1:0];
                    end
                    n_state = S_CHECK;
                end else if (r_dir == DIR_LEFT) begin
                    n_state = S_POP;
                end else begin
                    n_dir   = t_dir'(r_dir + 2'd1);
                    n_state = S_NBR;
                end
            end
            S_POP: begin
                n_depth = r_depth - DEPTH_W'(1);
                if (r_depth == DEPTH_W'(1)) begin
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_POPWAIT;
                end
            end
            S_POPWAIT: begin
                n_top_row = r_st_rd[IDX_W-1:COL_W];
                n_top_col = r_st_rd[COL_W-1:0];
                n_state   = S_CHECK;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dir       <= DIR_DOWN;
            r_depth     <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_grid_rows <= CFG_W'(10);
            r_grid_cols <= CFG_W'(15);
            r_cell_vld  <= '0;
        end else begin
            r_state     <= n_state;
            r_dir       <= n_dir;
            r_depth     <= n_depth;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_idx == REG_GRID_ROWS) begin
                r_grid_rows <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == REG_GRID_COLS) begin
                r_grid_cols <= i_cfg_data;
            end
            if (cm_we) begin
                r_cell_vld[cm_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_row   <= n_top_row;
        r_top_col   <= n_top_col;
        r_goal_row  <= n_goal_row;
        r_goal_col  <= n_goal_col;
        r_out_found <= n_out_found;
        r_cm_vld_rd <= r_cell_vld[nbr_idx];
    end

    always_ff @(posedge i_clk) begin
        if (cm_we) begin
            cell_mem[cm_waddr] <= cm_wdata;
        end
        r_cm_rd <= cell_mem[nbr_idx];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            stack_mem[st_waddr] <= st_wdata;
        end
        r_st_rd <= stack_mem[depth_less2[IDX_W-1:0]];
    end

endmodule

// ===== rtl/gmrs_checker.sv =====
// Port-level checker for the grid maze search unit and its bind statement.
`timescale 1ns / 1ps
`include "grid_maze_reachability_search_unit_defines.svh"

module gmrs_checker import gmrs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             o_in_stall,
    input  logic             i_func,
    input  logic             o_out_valid,
    input  logic             i_out_stall,
    input  logic             o_found
);

    logic search_accept;
    logic load_accept;

    assign search_accept = i_in_valid && !o_in_stall && (i_func == FUNC_SEARCH);
    assign load_accept   = i_in_valid && !o_in_stall && (i_func == FUNC_LOAD);

    `GMRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `GMRS_ASSERT_NEXT(a_found_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_found))
    `GMRS_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n, search_accept, o_in_stall)
    `GMRS_ASSERT_NEXT(a_load_free, i_clk, i_rst_n, load_accept, !o_in_stall)
    `GMRS_ASSERT_IMPLY(a_result_after_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind grid_maze_reachability_search_unit gmrs_checker u_gmrs_checker (.*);
